// ----- hw/rtl/keyframe_linear_interpolator_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Keyframe interpolator assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Checks that an expression holds at every clock edge outside reset.
`define KLI_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("keyframe interpolator check failed");
// Checks that a condition is followed by a consequence in the next cycle.
`define KLI_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("keyframe interpolator sequence check failed");
`else
`define KLI_ASSERT_ALWAYS(lbl, expr)
`define KLI_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- hw/rtl/kli_pkg.sv -----
// ---------------------------------------------------------------------------
// Keyframe interpolator package
// Shared constants, datapath operation codes and control structures.
// ---------------------------------------------------------------------------
package kli_pkg;

	// Fixed field widths.
	localparam int DW          = 32;
	localparam int VALUE_COUNT = 4;
	localparam int EW          = $clog2(VALUE_COUNT);
	localparam int FRAC_W      = 17;
	localparam int DIV_STEPS   = FRAC_W;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_KEY_COUNT = 1'b0;
	localparam logic CFG_HOLD_MODE = 1'b1;

	typedef logic signed [DW-1:0] word_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_START,
		DP_CHK_HINT,
		DP_CHK_END,
		DP_PROBE,
		DP_PROBE_HI,
		DP_DECIDE,
		DP_ROW0,
		DP_ROW1,
		DP_DIV,
		DP_MUL,
		DP_ADD,
		DP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t        op;
		logic          div_first;
		logic [EW-1:0] elem;
	} dp_cmd_t;

	typedef struct packed {
		logic out_range;
		logic search_ok;
		logic less;
		logic more;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/kli_item_if.sv -----
// ---------------------------------------------------------------------------
// Keyframe interpolator input channel
// Valid/ready channel carrying load and query items.
// ---------------------------------------------------------------------------
interface kli_item_if;
	import kli_pkg::*;

	logic       valid;
	logic       ready;
	logic       kind;
	logic [3:0] key_index;
	word_t      key_time;
	word_t      load_value_0;
	word_t      load_value_1;
	word_t      load_value_2;
	word_t      load_value_3;
	word_t      query_time;

	modport source (output valid, kind, key_index, key_time, load_value_0, load_value_1,
		load_value_2, load_value_3, query_time, input ready);
	modport sink (input valid, kind, key_index, key_time, load_value_0, load_value_1,
		load_value_2, load_value_3, query_time, output ready);
	modport mon (input valid, ready, kind, key_index, key_time, load_value_0, load_value_1,
		load_value_2, load_value_3, query_time);
endinterface

// ----- hw/rtl/kli_result_if.sv -----
// ---------------------------------------------------------------------------
// Keyframe interpolator result channel
// Valid/ready channel carrying one result beat per query.
// ---------------------------------------------------------------------------
interface kli_result_if;
	import kli_pkg::*;

	logic       valid;
	logic       ready;
	logic       found;
	logic [3:0] segment;
	word_t      out_value_0;
	word_t      out_value_1;
	word_t      out_value_2;
	word_t      out_value_3;

	modport source (output valid, found, segment, out_value_0, out_value_1, out_value_2,
		out_value_3, input ready);
	modport sink (input valid, found, segment, out_value_0, out_value_1, out_value_2,
		out_value_3, output ready);
endinterface

// ----- hw/rtl/kli_datapath.sv -----
// ---------------------------------------------------------------------------
// Keyframe interpolator datapath
// Key tables, search registers, serial divider, blend multiplier, output beat.
// ---------------------------------------------------------------------------
module kli_datapath #(
	parameter int MAX_KEYS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_wdata,
	input  kli_pkg::dp_cmd_t   cmd,
	output kli_pkg::dp_status_t status,
	kli_item_if.sink           item,
	kli_result_if.source       result
);
	import kli_pkg::*;

	localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

	// Configuration registers.
	logic [4:0] key_count_q;
	logic       hold_q;

	// Key storage: one time table and one row of values per key.
	word_t                    tmem [MAX_KEYS];
	logic [VALUE_COUNT*DW-1:0] vmem [MAX_KEYS];
	word_t                    trd_q;
	logic [VALUE_COUNT*DW-1:0] vrd_q;
	logic [IW-1:0]            t_addr;
	logic [IW-1:0]            v_addr;

	// Search state.
	logic [IW-1:0]   hint_q;
	logic [IW-1:0]   h_q;
	word_t           t_q;
	word_t           tl_q;
	logic            below_q;
	logic signed [IW:0] lo_q;
	logic signed [IW:0] hi_q;
	logic [IW-1:0]   m_q;
	logic [IW:0]     n;
	logic [IW-1:0]   nm1;
	logic [IW-1:0]   nm2;
	logic [IW-1:0]   h;
	logic [IW+1:0]   lh_sum;
	logic [IW-1:0]   m;

	// Divider and blend state.
	logic [DW:0]       d_q;
	logic [DW+1:0]     r_q;
	logic [DW+1:0]     r_sh;
	logic [FRAC_W-1:0] q_q;
	logic              zero_q;
	logic [FRAC_W-1:0] frac;
	word_t             row0_q [VALUE_COUNT];
	word_t             row1_q [VALUE_COUNT];
	logic signed [DW:0]   diff;
	logic signed [50:0]   prod_full;
	logic signed [47:0]   prod_q;

	// Working result and output beat register.
	logic       found_q;
	logic [3:0] seg_q;
	word_t      res_q  [VALUE_COUNT];
	logic       ov_q;
	logic       of_q;
	logic [3:0] os_q;
	word_t      ovals_q [VALUE_COUNT];

	// Effective key count and clamped hint.
	always_comb begin
		if (key_count_q < 5'd2) begin
			n = (IW+1)'(2);
		end else if (32'(key_count_q) > MAX_KEYS) begin
			n = (IW+1)'(MAX_KEYS);
		end else begin
			n = (IW+1)'(key_count_q);
		end
		nm1 = IW'(n - (IW+1)'(1));
		nm2 = IW'(n - (IW+1)'(2));
		h   = (hint_q > nm2) ? nm2 : hint_q;
		lh_sum = (IW+2)'(lo_q) + (IW+2)'(hi_q);
		m   = lh_sum[IW:1];
	end

	// Table read addresses follow the current operation.
	always_comb begin
		case (cmd.op)
			DP_START:    t_addr = h;
			DP_CHK_HINT: t_addr = (t_q < trd_q) ? '0 : nm1;
			DP_PROBE:    t_addr = m;
			DP_PROBE_HI: t_addr = m_q + IW'(1);
			default:     t_addr = m_q;
		endcase
		v_addr = (cmd.op == DP_ROW0) ? m_q + IW'(1) : m_q;
	end

	// Status toward the controller.
	always_comb begin
		status.out_range = below_q ? (t_q < trd_q) : (t_q > trd_q);
		status.search_ok = (lo_q <= hi_q);
		status.less      = (t_q < tl_q);
		status.more      = (t_q > trd_q);
		status.out_free  = !ov_q || result.ready;
	end

	// Divider step and blend product.
	always_comb begin
		r_sh = cmd.div_first ? r_q : {r_q[DW:0], 1'b0};
		frac = zero_q ? '0 : q_q;
		diff = (DW+1)'(row1_q[cmd.elem]) - (DW+1)'(row0_q[cmd.elem]);
		prod_full = diff * $signed({1'b0, frac});
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 5'd2;
			hold_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_COUNT: key_count_q <= cfg_wdata;
				CFG_HOLD_MODE: hold_q      <= cfg_wdata[0];
				default:       hold_q      <= hold_q;
			endcase
		end
	end

	// Key memories with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD && 32'(item.key_index) < MAX_KEYS) begin
			tmem[IW'(item.key_index)] <= item.key_time;
			vmem[IW'(item.key_index)] <= {item.load_value_3, item.load_value_2,
				item.load_value_1, item.load_value_0};
		end
		trd_q <= tmem[t_addr];
		vrd_q <= vmem[v_addr];
	end

	// Hint and output beat control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.op == DP_DECIDE && !status.less && !status.more) begin
				hint_q <= m_q;
			end
			if (cmd.op == DP_PUSH) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_START: begin
				t_q     <= item.query_time;
				h_q     <= h;
				found_q <= 1'b0;
				seg_q   <= '0;
				for (int i = 0; i < VALUE_COUNT; i++) begin
					res_q[i] <= '0;
				end
			end
			DP_CHK_HINT: below_q <= (t_q < trd_q);
			DP_CHK_END: begin
				if (below_q) begin
					lo_q <= '0;
					hi_q <= (IW+1)'(h_q);
				end else begin
					lo_q <= (IW+1)'(h_q);
					hi_q <= (IW+1)'(nm2);
				end
			end
			DP_PROBE:    m_q  <= m;
			DP_PROBE_HI: tl_q <= trd_q;
			DP_DECIDE: begin
				if (status.less) begin
					hi_q <= (IW+1)'(m_q) - (IW+1)'(1);
				end else if (status.more) begin
					lo_q <= (IW+1)'(m_q) + (IW+1)'(1);
				end else begin
					found_q <= 1'b1;
					seg_q   <= 4'(m_q);
					d_q     <= (DW+1)'(trd_q) - (DW+1)'(tl_q);
					r_q     <= (DW+2)'(t_q) - (DW+2)'(tl_q);
					zero_q  <= (trd_q == tl_q);
					q_q     <= '0;
				end
			end
			DP_ROW0: begin
				for (int i = 0; i < VALUE_COUNT; i++) begin
					row0_q[i] <= vrd_q[i*DW +: DW];
				end
			end
			DP_ROW1: begin
				for (int i = 0; i < VALUE_COUNT; i++) begin
					row1_q[i] <= vrd_q[i*DW +: DW];
				end
			end
			DP_DIV: begin
				if (r_sh >= {1'b0, d_q}) begin
					r_q <= r_sh - {1'b0, d_q};
					q_q <= {q_q[FRAC_W-2:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[FRAC_W-2:0], 1'b0};
				end
			end
			DP_MUL: prod_q <= prod_full[47:0];
			DP_ADD: res_q[cmd.elem] <= hold_q ? row0_q[cmd.elem]
				: row0_q[cmd.elem] + prod_q[47:16];
			DP_PUSH: begin
				of_q <= found_q;
				os_q <= seg_q;
				for (int i = 0; i < VALUE_COUNT; i++) begin
					ovals_q[i] <= res_q[i];
				end
			end
			default: t_q <= t_q;
		endcase
	end

	assign result.valid       = ov_q;
	assign result.found       = of_q;
	assign result.segment     = os_q;
	assign result.out_value_0 = ovals_q[0];
	assign result.out_value_1 = ovals_q[1];
	assign result.out_value_2 = ovals_q[2];
	assign result.out_value_3 = ovals_q[3];
endmodule

// ----- hw/rtl/kli_controller.sv -----
// ---------------------------------------------------------------------------
// Keyframe interpolator controller
// Sequences loads, the hinted binary search, the divider and the blend.
// ---------------------------------------------------------------------------
`include "keyframe_linear_interpolator_unit_macros.svh"

module kli_controller (
	input  logic                clk,
	input  logic                arst_n,
	kli_item_if.sink            item,
	input  kli_pkg::dp_status_t status,
	output kli_pkg::dp_cmd_t    cmd
);
	import kli_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_HINT, S_END, S_PROBE, S_PROBE_HI, S_DECIDE,
		S_ROW0, S_ROW1, S_DIV, S_MUL, S_ADD, S_DONE
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic [4:0]    cnt_q;
	logic [EW-1:0] elem_q;

	assign item.ready = (state_q == S_IDLE);

	// Next state and the operation for this cycle.
	always_comb begin
		state_d       = state_q;
		cmd.op        = DP_NONE;
		cmd.div_first = (cnt_q == 5'd0);
		cmd.elem      = elem_q;
		case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					if (item.kind == KIND_LOAD) begin
						cmd.op = DP_LOAD;
					end else begin
						cmd.op  = DP_START;
						state_d = S_HINT;
					end
				end
			end
			S_HINT: begin
				cmd.op  = DP_CHK_HINT;
				state_d = S_END;
			end
			S_END: begin
				cmd.op  = DP_CHK_END;
				state_d = status.out_range ? S_DONE : S_PROBE;
			end
			S_PROBE: begin
				if (status.search_ok) begin
					cmd.op  = DP_PROBE;
					state_d = S_PROBE_HI;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PROBE_HI: begin
				cmd.op  = DP_PROBE_HI;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.op  = DP_DECIDE;
				state_d = (status.less || status.more) ? S_PROBE : S_ROW0;
			end
			S_ROW0: begin
				cmd.op  = DP_ROW0;
				state_d = S_ROW1;
			end
			S_ROW1: begin
				cmd.op  = DP_ROW1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = DP_DIV;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op  = DP_MUL;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.op  = DP_ADD;
				state_d = (elem_q == EW'(VALUE_COUNT - 1)) ? S_DONE : S_MUL;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.op  = DP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			elem_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == S_ADD) begin
				elem_q <= elem_q + EW'(1);
			end else if (state_q != S_MUL) begin
				elem_q <= '0;
			end
		end
	end

	// A result beat is only pushed when the output register can take it.
	`KLI_ASSERT_ALWAYS(a_push_free, (cmd.op != DP_PUSH) || status.out_free)
	// The divider runs exactly its fixed number of steps.
	`KLI_ASSERT_NEXT(a_div_len, (state_q == S_DIV) && (cnt_q == 5'(DIV_STEPS - 1)), state_q == S_MUL)
	// A hit in the search moves on to fetch the key rows.
	`KLI_ASSERT_NEXT(a_hit_rows, (state_q == S_DECIDE) && !status.less && !status.more, state_q == S_ROW0)
endmodule

// ----- hw/rtl/keyframe_linear_interpolator_unit.sv -----
// A load is written to the key tables as it is accepted; a query found in the table steps through
// the hint and end checks, the search probes, both row reads, the 17-step divider and the shared
// blend multiplier before the cycle that registers its result beat.
// One item is in work at a time; the result register lets the next item enter while a result
// beat waits. Reset (arst_n low, asynchronous) clears control, the search hint, key_count to 2
// and hold_mode to 0; the key tables are undefined until loaded.
// ---------------------------------------------------------------------------
// Keyframe linear interpolator
// Top level joining the sequencing controller and the interpolation datapath.
// ---------------------------------------------------------------------------
module keyframe_linear_interpolator_unit #(
	parameter int MAX_KEYS = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       cfg_index,
	input logic [4:0] cfg_wdata,
	kli_item_if.sink  item,
	kli_result_if.source result
);
	import kli_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer.
	kli_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.status (status),
		.cmd    (cmd)
	);

	// Tables and arithmetic.
	kli_datapath #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.item      (item),
		.result    (result)
	);
endmodule
